// ----- rtl/drfp_pkg.sv -----
// Package for the driver reply frame parser.
// Holds the request types, the frame event passed between submodules and the
// shared constants. It depends on nothing else.
package drfp_pkg;

  localparam int MOTOR_COUNT   = 4;
  localparam int CHANNEL_COUNT = 2;

  localparam int MOTOR_IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int CHAN_IDX_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  localparam int WORD_COUNT = 4;
  localparam int PHASE_W    = 4;

  localparam logic [7:0] START_MARK = 8'h2A;
  localparam logic [7:0] END_MARK   = 8'h23;

  localparam logic [PHASE_W-1:0] PHASE_IDLE = 4'd0;
  localparam logic [PHASE_W-1:0] PHASE_END  = 4'd9;

  localparam logic [15:0] RESET_WORD_0 = 16'h0031;
  localparam logic [15:0] RESET_WORD_1 = 16'h0032;
  localparam logic [15:0] RESET_WORD_2 = 16'h0033;
  localparam logic [15:0] RESET_WORD_3 = 16'h0034;

  typedef struct packed {
    logic       channel;
    logic [7:0] data_byte;
    logic [7:0] motor_select;
  } in_item_t;

  typedef struct packed {
    logic              frame_channel;
    logic [15:0]       word_zero;
    logic [15:0]       word_one;
    logic [15:0]       word_two;
    logic [15:0]       word_three;
    logic              reset_frame;
    logic              restart_counted;
    logic signed [7:0] restart_count;
  } out_item_t;

  // A good frame completed by the current byte.
  typedef struct packed {
    logic                        done;
    logic                        channel;
    logic [WORD_COUNT-1:0][15:0] words;
    logic                        reset_frame;
  } frame_event_t;

endpackage

// ----- rtl/drfp_frame_assembler.sv -----
// Per-channel frame assembly: phase counters and word buffers.
// Depends on drfp_pkg.
module drfp_frame_assembler (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  drfp_pkg::in_item_t  item,
  output drfp_pkg::frame_event_t frame
);

  logic [drfp_pkg::PHASE_W-1:0] phase [drfp_pkg::CHANNEL_COUNT];
  logic [drfp_pkg::WORD_COUNT-1:0][15:0] word_buffer [drfp_pkg::CHANNEL_COUNT];

  logic [drfp_pkg::CHAN_IDX_W-1:0] ch_idx;
  logic                            ch_present;
  logic [drfp_pkg::PHASE_W-1:0]    ph;
  logic [drfp_pkg::PHASE_W-1:0]    phase_next;
  logic [drfp_pkg::PHASE_W-1:0]    ph_minus;
  logic [1:0]                      word_idx;
  logic                            in_word;
  logic [drfp_pkg::WORD_COUNT-1:0][15:0] words_cur;
  logic [15:0]                     word_next;

  assign ch_idx     = drfp_pkg::CHAN_IDX_W'(item.channel);
  assign ch_present = 32'(item.channel) < drfp_pkg::CHANNEL_COUNT;
  assign ph         = phase[ch_idx];
  assign words_cur  = word_buffer[ch_idx];
  assign ph_minus   = ph - 4'd1;
  assign word_idx   = ph_minus[2:1];
  assign in_word    = (ph != drfp_pkg::PHASE_IDLE) && (ph < drfp_pkg::PHASE_END);

  // Odd phases take the high byte and clear the low one; even phases fill the low byte.
  always_comb begin
    if (ph[0]) begin
      word_next = {item.data_byte, 8'h00};
    end else begin
      word_next = {words_cur[word_idx][15:8], item.data_byte};
    end
  end

  always_comb begin
    if (ph == drfp_pkg::PHASE_IDLE || ph > drfp_pkg::PHASE_END) begin
      phase_next = (item.data_byte == drfp_pkg::START_MARK) ? 4'd1 : drfp_pkg::PHASE_IDLE;
    end else if (in_word) begin
      phase_next = ph + 4'd1;
    end else begin
      phase_next = drfp_pkg::PHASE_IDLE;
    end
  end

  always_comb begin
    frame.done    = ch_present && (ph == drfp_pkg::PHASE_END) &&
                    (item.data_byte == drfp_pkg::END_MARK);
    frame.channel = item.channel;
    frame.words   = words_cur;
    frame.reset_frame = (words_cur[0] == drfp_pkg::RESET_WORD_0) &&
                        (words_cur[1] == drfp_pkg::RESET_WORD_1) &&
                        (words_cur[2] == drfp_pkg::RESET_WORD_2) &&
                        (words_cur[3] == drfp_pkg::RESET_WORD_3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < drfp_pkg::CHANNEL_COUNT; c++) begin
        phase[c] <= drfp_pkg::PHASE_IDLE;
      end
    end else if (step && ch_present) begin
      phase[ch_idx] <= phase_next;
    end
  end

  // Every word is rewritten before the end mark is checked, so no reset is needed.
  always_ff @(posedge clk) begin
    if (step && ch_present && in_word) begin
      word_buffer[ch_idx][word_idx] <= word_next;
    end
  end

`ifndef ASSERT_OFF
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase[0] <= drfp_pkg::PHASE_END)
    else $error("channel phase left its range");

  a_done_from_end: assert property (@(posedge clk) disable iff (rst)
    (step && frame.done) |=> (phase[$past(ch_idx)] == drfp_pkg::PHASE_IDLE))
    else $error("phase not back to idle after a completed frame");
`endif

endmodule

// ----- rtl/drfp_restart_tracker.sv -----
// Consecutive reset frame counter and per-motor restart counts.
// Depends on drfp_pkg.
module drfp_restart_tracker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  drfp_pkg::frame_event_t frame,
  input  logic [7:0]             motor_select,
  output logic                   restart_counted,
  output logic signed [7:0]      restart_count
);

  logic [7:0] consecutive_resets;
  logic [7:0] consecutive_resets_next;
  logic [7:0] restart_counts [drfp_pkg::MOTOR_COUNT];

  logic [drfp_pkg::MOTOR_IDX_W-1:0] sel_idx;
  logic                             sel_valid;
  logic [7:0]                       count_cur;
  logic [7:0]                       count_inc;

  assign sel_idx   = motor_select[drfp_pkg::MOTOR_IDX_W-1:0];
  assign sel_valid = 32'(motor_select) < drfp_pkg::MOTOR_COUNT;
  assign count_cur = sel_valid ? restart_counts[sel_idx] : 8'd0;
  assign count_inc = count_cur + 8'd1;

  assign consecutive_resets_next = frame.reset_frame ? consecutive_resets + 8'd1 : 8'd0;

  assign restart_counted = frame.reset_frame && sel_valid && (consecutive_resets_next == 8'd1);
  assign restart_count   = restart_counted ? $signed(count_inc) : $signed(count_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      consecutive_resets <= 8'd0;
      for (int m = 0; m < drfp_pkg::MOTOR_COUNT; m++) begin
        restart_counts[m] <= 8'd0;
      end
    end else if (step && frame.done) begin
      consecutive_resets <= consecutive_resets_next;
      if (restart_counted) begin
        restart_counts[sel_idx] <= count_inc;
      end
    end
  end

`ifndef ASSERT_OFF
  a_bump_after_zero: assert property (@(posedge clk) disable iff (rst)
    (step && frame.done && restart_counted) |-> (consecutive_resets == 8'd0))
    else $error("restart bumped while the reset run was not starting");

  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    (step && frame.done && !frame.reset_frame) |=> (consecutive_resets == 8'd0))
    else $error("reset run not cleared by an ordinary frame");
`endif

endmodule

// ----- rtl/driver_reply_frame_parser.sv -----
// Top level of the driver reply frame parser: input register, frame assembly,
// restart tracking and result register.
// Depends on drfp_pkg, drfp_frame_assembler and drfp_restart_tracker.
//
//   Channel   Direction  Handshake            Payload
//   in        request    in_valid / in_ready  drfp_pkg::in_item_t  (one serial byte)
//   out       result     out_valid/out_ready  drfp_pkg::out_item_t (one good frame)
//
// Each byte request is captured in an input register and processed from there
// into the result register; a stalled result can keep it waiting in the
// input register. One request is accepted every cycle while the result is not
// stalled; the pair of registers sets that rate.
// Reset (rst, synchronous) returns every channel to idle and clears the reset
// run counter and restart counts; both registers come up empty.
// A stalled result holds the processing stage, and the input register then
// holds its request, so in_ready falls only while both stages are full and
// the result is not being taken.
module driver_reply_frame_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  drfp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output drfp_pkg::out_item_t out_item
);

  // Input register.
  logic               in_held;
  drfp_pkg::in_item_t in_q;

  // The processing stage commits a request when the result register can take it.
  logic                   step;
  drfp_pkg::frame_event_t frame;
  logic                   restart_counted;
  logic signed [7:0]      restart_count;

  assign step     = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_item;
    end
  end

  drfp_frame_assembler u_assembler (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .item  (in_q),
    .frame (frame)
  );

  drfp_restart_tracker u_tracker (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .frame           (frame),
    .motor_select    (in_q.motor_select),
    .restart_counted (restart_counted),
    .restart_count   (restart_count)
  );

  // Result register. A request that completes no frame simply empties it
  // (the old result, if any, is being taken in this same cycle).
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= frame.done;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && frame.done) begin
      out_item.frame_channel   <= frame.channel;
      out_item.word_zero       <= frame.words[0];
      out_item.word_one        <= frame.words[1];
      out_item.word_two        <= frame.words[2];
      out_item.word_three      <= frame.words[3];
      out_item.reset_frame     <= frame.reset_frame;
      out_item.restart_counted <= restart_counted;
      out_item.restart_count   <= restart_count;
    end
  end

`ifndef ASSERT_OFF
  a_no_frame_no_result: assert property (@(posedge clk) disable iff (rst)
    (step && !frame.done) |=> !out_valid)
    else $error("result shown for a request that completed no frame");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && in_held))
    else $error("input stalled without a stalled result");

  a_counted_is_reset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_item.restart_counted || out_item.reset_frame))
    else $error("restart counted on a frame that is not a reset frame");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for driver_reply_frame_parser.
// Streams serial bytes on both channels and checks every reply frame that the
// block reports. It depends on drfp_pkg and driver_reply_frame_parser only.
module tb_top;

  localparam logic [drfp_pkg::PHASE_W-1:0] PHASE_FIRST_BYTE = 4'd1;
  localparam logic [3:0][15:0]             RESET_PATTERN    =
      {drfp_pkg::RESET_WORD_3, drfp_pkg::RESET_WORD_2,
       drfp_pkg::RESET_WORD_1, drfp_pkg::RESET_WORD_0};
  localparam int                           IDLE_PERCENT     = 14;
  localparam int                           RANDOM_BYTES     = 1620;
  localparam int                           WATCHDOG_LIMIT   = 2000;
  localparam int                           SETTLE_CYCLES    = 8;

  // Tracks the parser state as the block should hold it, and keeps the reply
  // frames that accepted bytes have caused but the block has not yet reported.
  class frame_checker;
    logic [drfp_pkg::PHASE_W-1:0] lane_phase [drfp_pkg::CHANNEL_COUNT];
    logic [15:0]                  words [drfp_pkg::CHANNEL_COUNT][drfp_pkg::WORD_COUNT];
    logic [7:0]                   reset_run;
    logic [7:0]                   restarts [drfp_pkg::MOTOR_COUNT];
    drfp_pkg::out_item_t          expected_frames [$];
    int                           mismatches;

    function new();
      for (int c = 0; c < drfp_pkg::CHANNEL_COUNT; c++) begin
        lane_phase[c] = drfp_pkg::PHASE_IDLE;
        for (int w = 0; w < drfp_pkg::WORD_COUNT; w++) words[c][w] = '0;
      end
      for (int m = 0; m < drfp_pkg::MOTOR_COUNT; m++) restarts[m] = '0;
      reset_run  = '0;
      mismatches = 0;
    endfunction

    // Advances the state of one channel by an accepted byte request.
    function void take_byte(drfp_pkg::in_item_t req);
      int unsigned                  ch;
      int unsigned                  idx;
      logic [drfp_pkg::PHASE_W-1:0] ph;
      bit                           is_reset;
      bit                           bumped;
      drfp_pkg::out_item_t          frame;
      ch = req.channel;
      if (ch >= drfp_pkg::CHANNEL_COUNT) return;
      ph = lane_phase[ch];
      if (ph == drfp_pkg::PHASE_IDLE || ph > drfp_pkg::PHASE_END) begin
        lane_phase[ch] = (req.data_byte == drfp_pkg::START_MARK) ?
                         PHASE_FIRST_BYTE : drfp_pkg::PHASE_IDLE;
        return;
      end
      if (ph < drfp_pkg::PHASE_END) begin
        // Odd phases carry the high byte and clear the low one.
        idx = (ph - 1) >> 1;
        if (ph[0]) words[ch][idx] = {req.data_byte, 8'h00};
        else words[ch][idx][7:0] = req.data_byte;
        lane_phase[ch] = ph + 1'b1;
        return;
      end
      lane_phase[ch] = drfp_pkg::PHASE_IDLE;
      if (req.data_byte != drfp_pkg::END_MARK) return;

      is_reset = words[ch][0] == drfp_pkg::RESET_WORD_0 &&
                 words[ch][1] == drfp_pkg::RESET_WORD_1 &&
                 words[ch][2] == drfp_pkg::RESET_WORD_2 &&
                 words[ch][3] == drfp_pkg::RESET_WORD_3;
      bumped = 1'b0;
      if (is_reset) begin
        reset_run = reset_run + 1'b1;
        if (reset_run == 8'd1 && req.motor_select < drfp_pkg::MOTOR_COUNT) begin
          restarts[req.motor_select] = restarts[req.motor_select] + 1'b1;
          bumped = 1'b1;
        end
      end else begin
        reset_run = '0;
      end
      frame.frame_channel   = ch[0];
      frame.word_zero       = words[ch][0];
      frame.word_one        = words[ch][1];
      frame.word_two        = words[ch][2];
      frame.word_three      = words[ch][3];
      frame.reset_frame     = is_reset;
      frame.restart_counted = bumped;
      frame.restart_count   = (req.motor_select < drfp_pkg::MOTOR_COUNT) ?
                              restarts[req.motor_select] : '0;
      expected_frames.push_back(frame);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in %s: expected %h, got %h", name, want, got);
      end
    endfunction

    // Compares a reported frame with the oldest one still awaited.
    function void check_frame(drfp_pkg::out_item_t got);
      drfp_pkg::out_item_t want;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("frame reported with none awaited: %h", got);
        return;
      end
      want = expected_frames.pop_front();
      compare_field("frame_channel", want.frame_channel, got.frame_channel);
      compare_field("word_zero", want.word_zero, got.word_zero);
      compare_field("word_one", want.word_one, got.word_one);
      compare_field("word_two", want.word_two, got.word_two);
      compare_field("word_three", want.word_three, got.word_three);
      compare_field("reset_frame", want.reset_frame, got.reset_frame);
      compare_field("restart_counted", want.restart_counted, got.restart_counted);
      compare_field("restart_count", want.restart_count, got.restart_count);
    endfunction

    function int awaited();
      return expected_frames.size();
    endfunction
  endclass

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  drfp_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  drfp_pkg::out_item_t out_item;

  frame_checker sb = new();

  // While set, neither side idles; this gives the block a long stretch at
  // full rate.
  bit quiet = 1'b0;
  int idle_cycles = 0;
  int random_bytes = 0;

  // Bytes waiting to be sent, one queue per serial channel. Sending picks
  // between the two at random so that frames on both channels interleave.
  drfp_pkg::in_item_t lane_zero [$];
  drfp_pkg::in_item_t lane_one [$];

  driver_reply_frame_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The result side: checks each reported frame, then decides whether to
  // stall the next cycle. Values are sampled before this edge's updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_frame(out_item);
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // A run that stops moving in either direction is a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly a valid motor; now and then any value, so that every select bit
  // toggles and out-of-range selects get through.
  function automatic logic [7:0] pick_motor();
    if ($urandom_range(99) < 85) return 8'($urandom_range(drfp_pkg::MOTOR_COUNT - 1));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {8'h00, 8'($urandom_range(255))};
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic void push_byte(bit ch, logic [7:0] b, logic [7:0] sel);
    drfp_pkg::in_item_t req;
    req.channel      = ch;
    req.data_byte    = b;
    req.motor_select = sel;
    if (ch) lane_one.push_back(req);
    else lane_zero.push_back(req);
  endfunction

  // Queues one whole frame: start mark, four words high byte first, and the
  // given closing byte. Only the closing byte's motor select matters.
  function automatic void add_frame(bit ch, logic [3:0][15:0] w, logic [7:0] last,
                                    logic [7:0] sel);
    push_byte(ch, drfp_pkg::START_MARK, 8'($urandom_range(255)));
    for (int i = 0; i < drfp_pkg::WORD_COUNT; i++) begin
      push_byte(ch, w[i][15:8], 8'($urandom_range(255)));
      push_byte(ch, w[i][7:0], 8'($urandom_range(255)));
    end
    push_byte(ch, last, sel);
  endfunction

  // One random piece of traffic for a channel. Most pieces are good frames,
  // some of them near misses of the reset pattern; the rest are frames with a
  // wrong closing byte and stray bytes while the channel is idle.
  function automatic void add_segment(bit ch);
    int               r;
    int               n;
    logic [3:0][15:0] w;
    logic [7:0]       b;
    r = $urandom_range(99);
    w = RESET_PATTERN;
    if (r < 35) begin
      add_frame(ch, w, drfp_pkg::END_MARK, pick_motor());
      random_bytes += 10;
    end else if (r < 65) begin
      for (int i = 0; i < drfp_pkg::WORD_COUNT; i++) w[i] = rand_word();
      add_frame(ch, w, drfp_pkg::END_MARK, pick_motor());
      random_bytes += 10;
    end else if (r < 72) begin
      w[$urandom_range(drfp_pkg::WORD_COUNT - 1)] ^= 16'h0001 << $urandom_range(15);
      add_frame(ch, w, drfp_pkg::END_MARK, pick_motor());
      random_bytes += 10;
    end else if (r < 84) begin
      if ($urandom_range(1)) begin
        for (int i = 0; i < drfp_pkg::WORD_COUNT; i++) w[i] = rand_word();
      end
      do b = 8'($urandom_range(255)); while (b == drfp_pkg::END_MARK);
      add_frame(ch, w, b, pick_motor());
      random_bytes += 10;
    end else begin
      // Stray bytes; a start mark among them is kept only now and then, as it
      // shifts the framing of everything that follows on this channel.
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(255));
        if (b == drfp_pkg::START_MARK && $urandom_range(3) != 0) b = 8'h00;
        push_byte(ch, b, 8'($urandom_range(255)));
      end
      random_bytes += n;
    end
  endfunction

  // Offers one byte request and holds it until the block takes it. A random
  // gap beforehand lowers valid.
  task automatic send_request(input drfp_pkg::in_item_t req);
    if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_item  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.take_byte(req);
  endtask

  task automatic send_lanes();
    drfp_pkg::in_item_t req;
    while (lane_zero.size() != 0 || lane_one.size() != 0) begin
      if (lane_one.size() == 0 || (lane_zero.size() != 0 && $urandom_range(1) == 0))
        req = lane_zero.pop_front();
      else
        req = lane_one.pop_front();
      send_request(req);
    end
  endtask

  // Holds the sender until every awaited frame has been reported.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.awaited() != 0);
  endtask

  initial begin
    logic [3:0][15:0] w;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: stray bytes on idle channels, a reset frame that bumps the
    // highest motor, and a frame of extreme words closed by a start mark,
    // which must be dropped.
    push_byte(1'b0, 8'h00, 8'h00);
    push_byte(1'b1, 8'hFF, 8'hFF);
    send_lanes();
    add_frame(1'b1, RESET_PATTERN, drfp_pkg::END_MARK, 8'(drfp_pkg::MOTOR_COUNT - 1));
    send_lanes();
    w = {16'hFFFF, 16'h0000, 16'h00FF, 16'hFF00};
    add_frame(1'b0, w, drfp_pkg::START_MARK, 8'hFF);
    send_lanes();
    drain();

    // Random traffic on both channels, with a stretch at full rate.
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      quiet = random_bytes >= 600 && random_bytes < 1000;
      repeat ($urandom_range(2, 1)) add_segment(1'b0);
      repeat ($urandom_range(2, 1)) add_segment(1'b1);
      send_lanes();
    end
    quiet = 1'b0;
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
